// File: rtl/ams_pkg.sv
// shared constants, types and codes for the accumulator machine stepper
package ams_pkg;

	localparam int MEM_WORDS = 100;
	localparam int ADDR_W    = 7;
	localparam int ALU_STEPS = 32;
	localparam int IN_W      = 40;
	localparam int OUT_W     = 152;

	localparam logic signed [31:0] WORD_MAX = 32'sd9999;
	localparam logic signed [31:0] WORD_MIN = -32'sd9999;

	// item kinds
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_STEP = 2'd1;
	localparam logic [1:0] KIND_PEEK = 2'd2;

	// opcodes
	localparam logic signed [31:0] OP_NONE   = 32'sd0;
	localparam logic signed [31:0] OP_READ   = 32'sd10;
	localparam logic signed [31:0] OP_WRITE  = 32'sd11;
	localparam logic signed [31:0] OP_LOAD   = 32'sd20;
	localparam logic signed [31:0] OP_STORE  = 32'sd21;
	localparam logic signed [31:0] OP_ADD    = 32'sd30;
	localparam logic signed [31:0] OP_SUB    = 32'sd31;
	localparam logic signed [31:0] OP_DIV    = 32'sd32;
	localparam logic signed [31:0] OP_MUL    = 32'sd33;
	localparam logic signed [31:0] OP_BR     = 32'sd40;
	localparam logic signed [31:0] OP_BRNEG  = 32'sd41;
	localparam logic signed [31:0] OP_BRZERO = 32'sd42;
	localparam logic signed [31:0] OP_HALT   = 32'sd43;
	localparam logic signed [31:0] DEC_BASE  = 32'sd100;

	// instruction words whose opcode field lies from read to halt, and the reciprocal split by the base
	localparam logic signed [31:0] DEC_LO    = OP_READ * DEC_BASE;
	localparam logic signed [31:0] DEC_HI    = (OP_HALT + 32'sd1) * DEC_BASE - 32'sd1;
	localparam logic [12:0]        DEC_RECIP = 13'd5243;
	localparam int                 DEC_SHIFT = 19;

	// status codes
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_HALT      = 4'd1;
	localparam logic [3:0] ST_ZERO_WORD = 4'd2;
	localparam logic [3:0] ST_PC_END    = 4'd3;
	localparam logic [3:0] ST_BAD_OP    = 4'd4;
	localparam logic [3:0] ST_DIV_ZERO  = 4'd5;
	localparam logic [3:0] ST_READ_REJ  = 4'd6;
	localparam logic [3:0] ST_LOAD_IGN  = 4'd7;
	localparam logic [3:0] ST_STOPPED   = 4'd8;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_READ_PC,
		S_DECODE,
		S_READ_OPD,
		S_EXEC,
		S_ALU_WAIT,
		S_READ_PEEK,
		S_PEEK,
		S_DONE
	} seq_state_t;

	typedef enum logic {
		ALU_DIV,
		ALU_MUL
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_rsp_t;

endpackage

// File: rtl/accumulator_machine_stepper.sv
// top level: sequencer, machine registers, program memory and shared alu
// sequence: a step reads the instruction word, decodes it, reads the operand, then executes
//   (multiply or divide then hold the shared alu until it finishes)
// throughput: one item at a time; the next item is taken once a result is registered
// the shared iterative alu sets the step time; memory has one registered read port
// reset: asynchronous active low, memory reads as zero via per-word valid bits, no sweep
module accumulator_machine_stepper import ams_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// fields from bit 0: word[31:0], peek_address[38:32], zero fill
	input  logic [IN_W-1:0]  s_tdata,
	// fields from bit 0: kind[1:0]
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// fields from bit 0: status[3:0], write_valid[4], write_location[11:5],
	// write_value[43:12], acc_value[75:44], program_counter[82:76],
	// fetched_instruction[114:83], peek_word[146:115], zero fill
	output logic [OUT_W-1:0] m_tdata
);

	localparam logic [ADDR_W-1:0] MW = ADDR_W'(MEM_WORDS);

	seq_state_t state_q, state_d;

	logic              [MEM_WORDS-1:0] valid_q;
	logic signed [31:0] acc_q;
	logic        [7:0]  pc_q;
	logic        [31:0] instr_q;
	logic [ADDR_W-1:0]  lp_q;
	logic               stop_q;
	logic signed [31:0] word_q;
	logic [ADDR_W-1:0]  paddr_q;
	logic signed [31:0] opc_q;
	logic        [7:0]  opd_q;
	logic        [3:0]  status_q;
	logic               wv_q;
	logic [ADDR_W-1:0]  wloc_q;
	logic        [31:0] wval_q;
	logic        [31:0] peek_q;
	logic               rvalid_q;
	logic               mvalid_q;
	logic [OUT_W-1:0]   mdata_q;

	logic               accept;
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic        [31:0] wdata;
	logic [ADDR_W-1:0]  raddr;
	logic               rd_ok;
	logic        [31:0] rdata;
	logic        [31:0] rword;
	logic               load_ok;
	logic               pc_ok;
	logic               opd_ok;
	logic               peek_ok;
	logic               read_ok;
	logic signed [31:0] in_word;
	logic [ADDR_W-1:0]  in_paddr;
	logic               out_free;
	logic               div_zero;
	logic               dec_ok;
	logic        [12:0] dec_x;
	logic        [25:0] dec_prod;
	logic        [5:0]  dec_op;
	logic        [12:0] dec_rem;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	logic        [31:0] alu_a;
	logic        [31:0] alu_b;
	logic        [31:0] alu_res;

	assign in_word  = s_tdata[31:0];
	assign in_paddr = s_tdata[38:32];
	assign accept   = s_tvalid && s_tready;
	assign s_tready = state_q == S_IDLE;
	assign out_free = !mvalid_q || m_tready;
	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;

	// range checks
	assign pc_ok    = !pc_q[7] && (pc_q[ADDR_W-1:0] < MW);
	assign opd_ok   = !opd_q[7] && (opd_q[ADDR_W-1:0] < MW);
	assign peek_ok  = in_paddr < MW;
	assign load_ok  = (lp_q < MW) && (word_q <= WORD_MAX) && (word_q >= WORD_MIN);
	assign read_ok  = (word_q <= WORD_MAX) && (word_q >= WORD_MIN);
	assign rword    = rvalid_q ? rdata : 32'd0;
	assign div_zero = rword == 32'd0;

	// opcode and operand split by reciprocal multiplication, opcode fields from read to halt only
	assign dec_ok   = ($signed(rword) >= DEC_LO) && ($signed(rword) <= DEC_HI);
	assign dec_x    = rword[12:0];
	assign dec_prod = {13'd0, dec_x} * {13'd0, DEC_RECIP};
	assign dec_op   = dec_prod[DEC_SHIFT +: 6];
	assign dec_rem  = dec_x - 13'(dec_op) * 13'(DEC_BASE);

	// program memory
	ams_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// shared divide and multiply unit
	ams_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.rsp    (alu_rsp),
		.res    (alu_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (s_tuser)
						KIND_LOAD: state_d = S_LOAD;
						KIND_STEP: state_d = (!stop_q && pc_ok) ? S_READ_PC : S_DONE;
						KIND_PEEK: state_d = peek_ok ? S_READ_PEEK : S_DONE;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_LOAD:      state_d = S_DONE;
			S_READ_PC:   state_d = S_DECODE;
			S_DECODE:    state_d = (rword == 32'd0) ? S_DONE : S_READ_OPD;
			S_READ_OPD:  state_d = S_EXEC;
			S_EXEC: begin
				if ((opc_q == OP_DIV && !div_zero) || opc_q == OP_MUL) begin
					state_d = S_ALU_WAIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_ALU_WAIT:  state_d = alu_rsp.done ? S_DONE : S_ALU_WAIT;
			S_READ_PEEK: state_d = S_PEEK;
			S_PEEK:      state_d = S_DONE;
			S_DONE:      state_d = out_free ? S_IDLE : S_DONE;
			default:     state_d = S_IDLE;
		endcase
	end

	// memory port and alu control
	always_comb begin
		we          = 1'b0;
		waddr       = lp_q;
		wdata       = word_q;
		raddr       = paddr_q;
		rd_ok       = 1'b0;
		alu_req     = '{start: 1'b0, op: ALU_DIV};
		alu_a       = acc_q;
		alu_b       = rword;
		case (state_q)
			S_LOAD: begin
				we = load_ok;
			end
			S_READ_PC: begin
				raddr = pc_q[ADDR_W-1:0];
				rd_ok = 1'b1;
			end
			S_READ_OPD: begin
				raddr = opd_q[ADDR_W-1:0];
				rd_ok = opd_ok;
			end
			S_EXEC: begin
				waddr = opd_q[ADDR_W-1:0];
				if (opc_q == OP_READ) begin
					we = read_ok && opd_ok;
				end else if (opc_q == OP_STORE) begin
					we    = opd_ok;
					wdata = acc_q;
				end else if (opc_q == OP_DIV) begin
					alu_req.start = !div_zero;
				end else if (opc_q == OP_MUL) begin
					alu_req.start = 1'b1;
					alu_req.op    = ALU_MUL;
				end
			end
			S_READ_PEEK: begin
				rd_ok = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// sequencer state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			rvalid_q <= 1'b0;
			mvalid_q <= 1'b0;
			acc_q    <= '0;
			pc_q     <= '0;
			instr_q  <= '0;
			lp_q     <= '0;
			stop_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rvalid_q <= rd_ok && valid_q[raddr];
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			// result register: set when a result is finished, cleared when taken
			if (state_q == S_DONE && out_free) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && s_tuser == KIND_STEP && !stop_q && !pc_ok) begin
						stop_q <= 1'b1;
					end
				end
				S_LOAD: begin
					if (load_ok) begin
						lp_q <= lp_q + ADDR_W'(1);
					end
				end
				S_DECODE: begin
					instr_q <= rword;
					if (rword == 32'd0) begin
						stop_q <= 1'b1;
					end
				end
				S_EXEC: begin
					case (opc_q)
						OP_READ:   pc_q <= read_ok ? pc_q + 8'd1 : pc_q;
						OP_WRITE:  pc_q <= pc_q + 8'd1;
						OP_LOAD: begin
							acc_q <= rword;
							pc_q  <= pc_q + 8'd1;
						end
						OP_STORE:  pc_q <= pc_q + 8'd1;
						OP_ADD: begin
							acc_q <= acc_q + rword;
							pc_q  <= pc_q + 8'd1;
						end
						OP_SUB: begin
							acc_q <= acc_q - rword;
							pc_q  <= pc_q + 8'd1;
						end
						OP_DIV: begin
							if (div_zero) begin
								stop_q <= 1'b1;
							end
						end
						OP_MUL:    pc_q <= pc_q;
						OP_BR:     pc_q <= opd_q;
						OP_BRNEG:  pc_q <= acc_q[31] ? opd_q : pc_q + 8'd1;
						OP_BRZERO: pc_q <= (acc_q == 32'sd0) ? opd_q : pc_q + 8'd1;
						default:   stop_q <= 1'b1;
					endcase
				end
				S_ALU_WAIT: begin
					if (alu_rsp.done) begin
						acc_q <= alu_res;
						pc_q  <= pc_q + 8'd1;
					end
				end
				default: begin
					stop_q <= stop_q;
				end
			endcase
		end
	end

	// item payload and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					word_q   <= in_word;
					paddr_q  <= in_paddr;
					wv_q     <= 1'b0;
					wloc_q   <= '0;
					wval_q   <= '0;
					peek_q   <= '0;
					status_q <= ST_OK;
					if (s_tuser == KIND_STEP) begin
						if (stop_q) begin
							status_q <= ST_STOPPED;
						end else if (!pc_ok) begin
							status_q <= ST_PC_END;
						end
					end
				end
			end
			S_LOAD: begin
				if (!load_ok) begin
					status_q <= ST_LOAD_IGN;
				end
			end
			S_DECODE: begin
				opc_q <= dec_ok ? 32'(dec_op) : OP_NONE;
				opd_q <= {1'b0, dec_rem[6:0]};
				if (rword == 32'd0) begin
					status_q <= ST_ZERO_WORD;
				end
			end
			S_EXEC: begin
				case (opc_q)
					OP_READ: begin
						if (!read_ok) begin
							status_q <= ST_READ_REJ;
						end
					end
					OP_WRITE: begin
						wv_q   <= 1'b1;
						wloc_q <= opd_q[ADDR_W-1:0];
						wval_q <= rword;
					end
					OP_DIV: begin
						if (div_zero) begin
							status_q <= ST_DIV_ZERO;
						end
					end
					OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_MUL, OP_BR, OP_BRNEG,
					OP_BRZERO: begin
						status_q <= ST_OK;
					end
					OP_HALT:  status_q <= ST_HALT;
					default:  status_q <= ST_BAD_OP;
				endcase
			end
			S_PEEK: begin
				peek_q <= rword;
			end
			S_DONE: begin
				if (out_free) begin
					mdata_q <= {5'd0, peek_q, instr_q, pc_q[ADDR_W-1:0], acc_q,
						wval_q, wloc_q, wv_q, status_q};
				end
			end
			default: begin
				peek_q <= peek_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	// load pointer never passes the end of memory
	a_lp_range: assert property (@(posedge clk) disable iff (!arst_n)
		lp_q <= MW)
		else $error("load pointer beyond memory");

	// a non-negative program counter stays at most one past the end
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		!pc_q[7] |-> pc_q[ADDR_W-1:0] <= MW)
		else $error("program counter out of range");

	// the alu only finishes while the sequencer waits for it
	a_alu_done: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_ALU_WAIT)
		else $error("alu finished outside a wait state");

	// no memory write outside load and execute
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_LOAD || state_q == S_EXEC))
		else $error("memory write in wrong state");

	// a stopped machine stays stopped
	a_stop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |=> stop_q)
		else $error("stopped flag cleared");
`endif

endmodule

// File: rtl/ams_ram.sv
// generic single write port ram with registered read
module ams_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/ams_alu.sv
// iterative signed divider and wrapping multiplier, one bit a cycle
module ams_alu import ams_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  alu_req_t    req,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output alu_rsp_t    rsp,
	output logic [31:0] res
);

	localparam int CNT_W = $clog2(ALU_STEPS + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	alu_op_t          op_q;
	logic             qneg_q;
	logic [31:0]      r_q;
	logic [31:0]      x_q;
	logic [31:0]      d_q;
	logic [32:0]      trial;
	logic             ge;

	// control: step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= CNT_W'(ALU_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division step
	assign trial = {r_q, x_q[31]};
	assign ge    = trial >= {1'b0, d_q};

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			r_q  <= '0;
			if (req.op == ALU_DIV) begin
				x_q    <= a[31] ? (~a + 32'd1) : a;
				d_q    <= b[31] ? (~b + 32'd1) : b;
				qneg_q <= a[31] ^ b[31];
			end else begin
				x_q    <= b;
				d_q    <= a;
				qneg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (op_q == ALU_DIV) begin
				r_q <= ge ? 32'(trial - {1'b0, d_q}) : trial[31:0];
				x_q <= {x_q[30:0], ge};
			end else begin
				if (x_q[0]) begin
					r_q <= r_q + d_q;
				end
				d_q <= {d_q[30:0], 1'b0};
				x_q <= {1'b0, x_q[31:1]};
			end
		end
	end

	// result select, with sign correction of the quotient
	always_comb begin
		if (op_q == ALU_DIV) begin
			res = qneg_q ? (~x_q + 32'd1) : x_q;
		end else begin
			res = r_q;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;

endmodule
